// ===== hdl/sfr_pkg.sv =====
// Types and constants shared by the serial frame receiver.
// Depends on nothing; imported by serial_frame_receiver_unit.
`default_nettype none

package sfr_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_timeout;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_address;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
  } out_item_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_FILTER_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE       = 3'd4;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_TIMEOUT  = 3'd1;
  localparam logic [2:0] STAT_BAD_LEN  = 3'd2;
  localparam logic [2:0] STAT_BAD_END  = 3'd3;
  localparam logic [2:0] STAT_BAD_SUM  = 3'd4;

  localparam logic [7:0] RST_DEVICE_ADDRESS = 8'h00;
  localparam logic       RST_ADDR_FILTER_EN = 1'b1;
  localparam logic [5:0] RST_MAX_FRAME_LEN  = 6'd23;
  localparam logic [7:0] RST_START_BYTE     = 8'hFF;
  localparam logic [7:0] RST_END_BYTE       = 8'hED;

  // Frame layout: start, length, address, body..., check, end.
  localparam logic [7:0] MIN_FRAME_LEN = 8'd6;
  localparam logic [7:0] BODY_OFFSET   = 8'd3;
  localparam logic [7:0] TRAILER_LEN   = 8'd2;

endpackage

`default_nettype wire

// ===== hdl/serial_frame_receiver_unit.sv =====
// Serial frame receiver: deframes start/length/address/body/check/end frames.
// Uses sfr_pkg for payload types and codes, and sfr_ram for the body store.
//
// Usage: each input request carries one received byte, or a timeout flag.
// A byte is taken while the receiver hunts for or parses a frame. Body bytes
// are written to a RAM of MAX_FRAME_BYTES entries as they arrive, and the
// running sum of all bytes before the check byte is kept in a register.
// A frame error (timeout, bad length, bad end byte, bad checksum) gives one
// status request on the output in the cycle after the offending input request.
// A good frame, once its end byte is taken, drains the body from the RAM:
// for each body byte a RAM read is issued, its registered data is then put
// in the output register when that is free, and only then is the next read
// issued, so a frame of length L gives L-5 output requests.
// Input ready is low during that drain. Both output paths go through one
// output register, so an input byte is taken whenever that register is
// empty or being emptied; when the output stalls, input stalls behind it.
// Configuration writes are always taken. Reset clears the registers, but
// for the output item register, to their defaults and returns the parser to
// hunting for the start byte; the RAM is not cleared.
`default_nettype none

module serial_frame_receiver_unit
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  localparam int unsigned AW  = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned BIW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [7:0] MaxLen8 = 8'(MAX_FRAME_BYTES);

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_LEN   = 5'b00010,
    ST_ADDR  = 5'b00100,
    ST_BODY  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [BIW-1:0]  byte_index_r, byte_index_nxt;
  logic [7:0]      frame_length_r, frame_length_nxt;
  logic [7:0]      frame_addr_r, frame_addr_nxt;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic [7:0]      check_byte_r, check_byte_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic            rd_pend_r, rd_pend_nxt;

  logic [7:0]      dev_addr_r;
  logic            filt_en_r;
  logic [5:0]      max_len_r;
  logic [7:0]      start_byte_r;
  logic [7:0]      end_byte_r;

  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            slot_free;
  logic            in_take;
  logic            emit;
  out_item_t       emit_item;
  logic [7:0]      limit8;
  logic [7:0]      pos8;
  logic [AW-1:0]   last_idx;
  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_rdata;

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_body_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.rx_byte),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r != ST_DRAIN) && slot_free;
  assign in_take   = in_valid && in_ready;
  assign limit8    = ({2'b00, max_len_r} > MaxLen8) ? MaxLen8 : {2'b00, max_len_r};
  assign pos8      = 8'(byte_index_r) + TRAILER_LEN;
  assign ram_waddr = AW'(8'(byte_index_r) - BODY_OFFSET);
  assign last_idx  = AW'(frame_length_r - MIN_FRAME_LEN);

  // Body writes and drain reads never overlap: the drain starts only after
  // the last body byte has been written, so no forwarding is needed.
  always_comb begin
    state_nxt        = state_r;
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    frame_addr_nxt   = frame_addr_r;
    running_sum_nxt  = running_sum_r;
    check_byte_nxt   = check_byte_r;
    rd_ptr_nxt       = rd_ptr_r;
    rd_pend_nxt      = rd_pend_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    emit             = 1'b0;
    emit_item        = '{status: STAT_OK, frame_address: frame_addr_r, data_byte: 8'h00,
                         data_valid: 1'b0, last: 1'b1};

    unique case (state_r)
      ST_HUNT: begin
        if (in_take && !in_item.rx_timeout && in_item.rx_byte == start_byte_r) begin
          state_nxt        = ST_LEN;
          byte_index_nxt   = BIW'(1);
          frame_length_nxt = 8'h00;
          frame_addr_nxt   = 8'h00;
          check_byte_nxt   = 8'h00;
          running_sum_nxt  = in_item.rx_byte;
        end
      end
      ST_LEN, ST_ADDR, ST_BODY: begin
        if (in_take) begin
          if (in_item.rx_timeout) begin
            emit             = 1'b1;
            emit_item.status = STAT_TIMEOUT;
            state_nxt        = ST_HUNT;
          end else if (state_r == ST_LEN) begin
            frame_length_nxt = in_item.rx_byte;
            running_sum_nxt  = running_sum_r + in_item.rx_byte;
            byte_index_nxt   = BIW'(2);
            state_nxt        = ST_ADDR;
          end else if (state_r == ST_ADDR) begin
            frame_addr_nxt   = in_item.rx_byte;
            running_sum_nxt  = running_sum_r + in_item.rx_byte;
            byte_index_nxt   = BIW'(3);
            emit_item.frame_address = in_item.rx_byte;
            if (filt_en_r && in_item.rx_byte != dev_addr_r) begin
              state_nxt = ST_HUNT;
            end else if (frame_length_r < MIN_FRAME_LEN || frame_length_r > limit8) begin
              emit             = 1'b1;
              emit_item.status = STAT_BAD_LEN;
              state_nxt        = ST_HUNT;
            end else begin
              state_nxt = ST_BODY;
            end
          end else if (pos8 < frame_length_r) begin
            ram_we          = 1'b1;
            running_sum_nxt = running_sum_r + in_item.rx_byte;
            byte_index_nxt  = byte_index_r + BIW'(1);
          end else if (pos8 == frame_length_r) begin
            check_byte_nxt = in_item.rx_byte;
            byte_index_nxt = byte_index_r + BIW'(1);
          end else if (in_item.rx_byte != end_byte_r) begin
            emit             = 1'b1;
            emit_item.status = STAT_BAD_END;
            state_nxt        = ST_HUNT;
          end else if (check_byte_r != running_sum_r) begin
            emit             = 1'b1;
            emit_item.status = STAT_BAD_SUM;
            state_nxt        = ST_HUNT;
          end else begin
            rd_ptr_nxt  = '0;
            rd_pend_nxt = 1'b0;
            state_nxt   = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!rd_pend_r) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (slot_free) begin
          emit                 = 1'b1;
          emit_item.data_byte  = ram_rdata;
          emit_item.data_valid = 1'b1;
          emit_item.last       = (rd_ptr_r == last_idx);
          rd_pend_nxt          = 1'b0;
          if (rd_ptr_r == last_idx) begin
            state_nxt = ST_HUNT;
          end else begin
            rd_ptr_nxt = rd_ptr_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_HUNT;
      byte_index_r   <= '0;
      frame_length_r <= 8'h00;
      frame_addr_r   <= 8'h00;
      running_sum_r  <= 8'h00;
      check_byte_r   <= 8'h00;
      rd_ptr_r       <= '0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
      frame_addr_r   <= frame_addr_nxt;
      running_sum_r  <= running_sum_nxt;
      check_byte_r   <= check_byte_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      rd_pend_r      <= rd_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= RST_DEVICE_ADDRESS;
      filt_en_r    <= RST_ADDR_FILTER_EN;
      max_len_r    <= RST_MAX_FRAME_LEN;
      start_byte_r <= RST_START_BYTE;
      end_byte_r   <= RST_END_BYTE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r   <= cfg_wdata;
        CFG_ADDR_FILTER_EN: filt_en_r    <= cfg_wdata[0];
        CFG_MAX_FRAME_LEN:  max_len_r    <= cfg_wdata[5:0];
        CFG_START_BYTE:     start_byte_r <= cfg_wdata;
        CFG_END_BYTE:       end_byte_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_BODY && in_take))
    else $error("body store written outside the body phase");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.data_valid) |->
      (out_item_r.last && out_item_r.data_byte == 8'h00 && out_item_r.status != STAT_OK))
    else $error("malformed status request");

  a_body_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY || state_r == ST_DRAIN) |->
      (frame_length_r >= MIN_FRAME_LEN && frame_length_r <= MaxLen8))
    else $error("frame length out of range in body or drain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.data_valid && out_item_r.last) |-> (state_r == ST_HUNT))
    else $error("drain still running after final body byte");

endmodule

`default_nettype wire

// ===== hdl/sfr_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data; no dependencies.
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
